// ----- rtl/core/vdq_pkg.sv -----
package vdq_pkg;

  // Default coordinate width
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // Octant boundaries (2j+1)*pi/128, j = 0..NUM_BOUNDS-1
  localparam int unsigned NUM_BOUNDS   = 16;
  localparam int unsigned CNT_W        = $clog2(NUM_BOUNDS + 1);
  localparam int unsigned TAYLOR_TERMS = 14;

  // Heading steps, 1/128 turn each
  localparam int unsigned DIR_W = 7;
  localparam logic [7:0] STEP_QUARTER = 8'd32;
  localparam logic [7:0] STEP_HALF    = 8'd64;
  localparam logic [7:0] STEP_FULL    = 8'd128;

  // Fixed point with 62 fraction bits
  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
  localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

  // Control bits carried along the cell row
  typedef struct packed {
    logic valid;
    logic swapped;
    logic x_neg;
    logic y_neg;
  } ctrl_t;

  // (a*b) >> 62, truncated to 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Truncating unsigned quotient by shift and subtract; elaboration only
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine or cosine of boundary j from a truncated Taylor series; elaboration only
  function automatic logic [63:0] bound_trig(input int unsigned j, input logic want_cos);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] st;
    logic [63:0] ss;
    logic [63:0] ct;
    logic [63:0] cs;
    logic [63:0] sdiv;
    logic [63:0] cdiv;
    x  = (PI_Q62 >> 7) * (64'(j) * 64'd2 + 64'd1);
    x2 = mul_q62(x, x);
    st = x;
    ss = x;
    ct = ONE_Q62;
    cs = ONE_Q62;
    for (int unsigned n = 1; n <= TAYLOR_TERMS; n++) begin
      sdiv = 64'((2 * n) * (2 * n + 1));
      cdiv = 64'((2 * n - 1) * (2 * n));
      st = div_u64(mul_q62(st, x2), sdiv);
      ct = div_u64(mul_q62(ct, x2), cdiv);
      if (n[0]) begin
        ss = ss - st;
        cs = cs - ct;
      end else begin
        ss = ss + st;
        cs = cs + ct;
      end
    end
    return want_cos ? cs : ss;
  endfunction

  function automatic logic [63:0] bound_sin(input int unsigned j);
    return bound_trig(j, 1'b0);
  endfunction

  function automatic logic [63:0] bound_cos(input int unsigned j);
    return bound_trig(j, 1'b1);
  endfunction

endpackage

// ----- rtl/core/vdq_if.sv -----
interface vdq_in_if #(
  parameter int unsigned COORD_WIDTH = vdq_pkg::COORD_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_WIDTH-1:0]  front_x;
  logic signed [COORD_WIDTH-1:0]  front_y;
  logic signed [COORD_WIDTH-1:0]  back_x;
  logic signed [COORD_WIDTH-1:0]  back_y;

  modport source (output valid, front_x, front_y, back_x, back_y, input ready);
  modport sink   (input valid, front_x, front_y, back_x, back_y, output ready);
endinterface

interface vdq_out_if;
  logic                        valid;
  logic                        ready;
  logic [vdq_pkg::DIR_W-1:0]   direction;

  modport source (output valid, direction, input ready);
  modport sink   (input valid, direction, output ready);
endinterface

// ----- rtl/core/vdq_fold.sv -----
module vdq_fold #(
  parameter int unsigned COORD_WIDTH = vdq_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] front_x_i,
  input  logic signed [COORD_WIDTH-1:0] front_y_i,
  input  logic signed [COORD_WIDTH-1:0] back_x_i,
  input  logic signed [COORD_WIDTH-1:0] back_y_i,
  output vdq_pkg::ctrl_t                ctrl_o,
  output logic [COORD_WIDTH-1:0]        u_o,
  output logic [COORD_WIDTH-1:0]        v_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;

  logic                 valid_q;
  logic signed [DW-1:0] dx_q;
  logic signed [DW-1:0] dy_q;
  logic signed [DW-1:0] dx_d;
  logic signed [DW-1:0] dy_d;

  logic [DW-1:0]          ndx;
  logic [DW-1:0]          ndy;
  logic [COORD_WIDTH-1:0] ax;
  logic [COORD_WIDTH-1:0] ay;
  logic                   swap;

  vdq_pkg::ctrl_t         ctrl_q;
  vdq_pkg::ctrl_t         ctrl_d;
  logic [COORD_WIDTH-1:0] u_q;
  logic [COORD_WIDTH-1:0] v_q;

  // Difference at full precision, one bit wider than the coordinates
  assign dx_d = {front_x_i[COORD_WIDTH-1], front_x_i} - {back_x_i[COORD_WIDTH-1], back_x_i};
  assign dy_d = {front_y_i[COORD_WIDTH-1], front_y_i} - {back_y_i[COORD_WIDTH-1], back_y_i};

  // Magnitude always fits the coordinate width
  assign ndx  = -dx_q;
  assign ndy  = -dy_q;
  assign ax   = dx_q[DW-1] ? ndx[COORD_WIDTH-1:0] : dx_q[COORD_WIDTH-1:0];
  assign ay   = dy_q[DW-1] ? ndy[COORD_WIDTH-1:0] : dy_q[COORD_WIDTH-1:0];
  assign swap = ay > ax;

  always_comb begin
    ctrl_d.valid   = valid_q;
    ctrl_d.swapped = swap;
    ctrl_d.x_neg   = dx_q[DW-1];
    ctrl_d.y_neg   = dy_q[DW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ctrl_q  <= '0;
    end else if (adv_i) begin
      valid_q <= valid_i;
      ctrl_q  <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      u_q  <= swap ? ay : ax;
      v_q  <= swap ? ax : ay;
    end
  end

  assign ctrl_o = ctrl_q;
  assign u_o    = u_q;
  assign v_o    = v_q;

endmodule

// ----- rtl/core/vdq_cell.sv -----
module vdq_cell #(
  parameter int unsigned COORD_WIDTH = vdq_pkg::COORD_WIDTH_DEF,
  parameter int unsigned BOUND_IDX   = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  vdq_pkg::ctrl_t                ctrl_i,
  input  logic [COORD_WIDTH-1:0]        u_i,
  input  logic [COORD_WIDTH-1:0]        v_i,
  input  logic [vdq_pkg::CNT_W-1:0]     cnt_i,
  output vdq_pkg::ctrl_t                ctrl_o,
  output logic [COORD_WIDTH-1:0]        u_o,
  output logic [COORD_WIDTH-1:0]        v_o,
  output logic [vdq_pkg::CNT_W-1:0]     cnt_o
);

  localparam logic [63:0] SinQ  = vdq_pkg::bound_sin(BOUND_IDX);
  localparam logic [63:0] CosQ  = vdq_pkg::bound_cos(BOUND_IDX);
  localparam logic [31:0] SinHi = SinQ[63:32];
  localparam logic [31:0] SinLo = SinQ[31:0];
  localparam logic [31:0] CosHi = CosQ[63:32];
  localparam logic [31:0] CosLo = CosQ[31:0];
  localparam int unsigned PW    = COORD_WIDTH + 32;
  localparam int unsigned SW    = COORD_WIDTH + 64;

  // Stage a: partial products
  vdq_pkg::ctrl_t              ctrl_a_q;
  logic [COORD_WIDTH-1:0]      u_a_q;
  logic [COORD_WIDTH-1:0]      v_a_q;
  logic [vdq_pkg::CNT_W-1:0]   cnt_a_q;
  logic [PW-1:0]               vch_q;
  logic [PW-1:0]               vcl_q;
  logic [PW-1:0]               ush_q;
  logic [PW-1:0]               usl_q;

  // Stage b: full products
  vdq_pkg::ctrl_t              ctrl_b_q;
  logic [COORD_WIDTH-1:0]      u_b_q;
  logic [COORD_WIDTH-1:0]      v_b_q;
  logic [vdq_pkg::CNT_W-1:0]   cnt_b_q;
  logic [SW-1:0]               lhs_q;
  logic [SW-1:0]               rhs_q;
  logic [SW-1:0]               lhs_d;
  logic [SW-1:0]               rhs_d;

  // Stage c: boundary count
  vdq_pkg::ctrl_t              ctrl_c_q;
  logic [COORD_WIDTH-1:0]      u_c_q;
  logic [COORD_WIDTH-1:0]      v_c_q;
  logic [vdq_pkg::CNT_W-1:0]   cnt_c_q;
  logic [vdq_pkg::CNT_W-1:0]   cnt_c_d;

  assign lhs_d   = {vch_q, 32'd0} + SW'(vcl_q);
  assign rhs_d   = {ush_q, 32'd0} + SW'(usl_q);
  // Count the boundary when v*cos(b) > u*sin(b)
  assign cnt_c_d = cnt_b_q + vdq_pkg::CNT_W'(lhs_q > rhs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
      ctrl_b_q <= '0;
      ctrl_c_q <= '0;
    end else if (adv_i) begin
      ctrl_a_q <= ctrl_i;
      ctrl_b_q <= ctrl_a_q;
      ctrl_c_q <= ctrl_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      u_a_q   <= u_i;
      v_a_q   <= v_i;
      cnt_a_q <= cnt_i;
      vch_q   <= PW'(v_i) * PW'(CosHi);
      vcl_q   <= PW'(v_i) * PW'(CosLo);
      ush_q   <= PW'(u_i) * PW'(SinHi);
      usl_q   <= PW'(u_i) * PW'(SinLo);

      u_b_q   <= u_a_q;
      v_b_q   <= v_a_q;
      cnt_b_q <= cnt_a_q;
      lhs_q   <= lhs_d;
      rhs_q   <= rhs_d;

      u_c_q   <= u_b_q;
      v_c_q   <= v_b_q;
      cnt_c_q <= cnt_c_d;
    end
  end

  assign ctrl_o = ctrl_c_q;
  assign u_o    = u_c_q;
  assign v_o    = v_c_q;
  assign cnt_o  = cnt_c_q;

endmodule

// ----- rtl/core/vector_direction_quantizer.sv -----
// Channel   Dir  Modport            Word
// item_i    in   vdq_in_if.sink     front_x, front_y, back_x, back_y (signed, COORD_WIDTH)
// result_o  out  vdq_out_if.source  direction (7 bit, 0..127)
//
// The path runs through two fold stages, three stages in each of the 16 boundary cells,
// and the output register. One word is accepted every cycle while the skid register is empty.
// Reset clears only valid and control bits; the pipeline is empty and ready right after reset.
// A stalled result waits in the output register; one more word parks in the skid
// register, and only then does the whole row hold and item_i.ready drop.
module vector_direction_quantizer #(
  parameter int unsigned COORD_WIDTH = vdq_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vdq_in_if.sink      item_i,
  vdq_out_if.source   result_o
);

  localparam int unsigned NB = vdq_pkg::NUM_BOUNDS;

  // Cell row: index k feeds cell k, index NB is the row's output
  vdq_pkg::ctrl_t              row_ctrl [NB+1];
  logic [COORD_WIDTH-1:0]      row_u    [NB+1];
  logic [COORD_WIDTH-1:0]      row_v    [NB+1];
  logic [vdq_pkg::CNT_W-1:0]   row_cnt  [NB+1];

  logic                        adv;
  logic                        take;

  // Unfold
  vdq_pkg::ctrl_t              tail_ctrl;
  logic [vdq_pkg::CNT_W-1:0]   tail_cnt;
  logic [7:0]                  oct_step;
  logic [7:0]                  quad_step;
  logic [7:0]                  dir_full;
  logic [vdq_pkg::DIR_W-1:0]   dir_new;

  // Output register and skid register
  logic                        out_valid_q;
  logic                        out_valid_d;
  logic [vdq_pkg::DIR_W-1:0]   out_dir_q;
  logic [vdq_pkg::DIR_W-1:0]   out_dir_d;
  logic                        skid_valid_q;
  logic                        skid_valid_d;
  logic [vdq_pkg::DIR_W-1:0]   skid_dir_q;
  logic [vdq_pkg::DIR_W-1:0]   skid_dir_d;

  // Advance the whole row unless the skid register is occupied
  assign adv          = !skid_valid_q;
  assign item_i.ready = adv;
  assign take         = out_valid_q && result_o.ready;

  // Fold the difference vector into the first octant
  vdq_fold #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_fold (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (item_i.valid),
    .front_x_i (item_i.front_x),
    .front_y_i (item_i.front_y),
    .back_x_i  (item_i.back_x),
    .back_y_i  (item_i.back_y),
    .ctrl_o    (row_ctrl[0]),
    .u_o       (row_u[0]),
    .v_o       (row_v[0])
  );

  assign row_cnt[0] = '0;

  // One cell per octant boundary; each adds one if the angle lies above its boundary
  for (genvar k = 0; k < NB; k++) begin : g_cell
    vdq_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .BOUND_IDX   (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctrl_i (row_ctrl[k]),
      .u_i    (row_u[k]),
      .v_i    (row_v[k]),
      .cnt_i  (row_cnt[k]),
      .ctrl_o (row_ctrl[k+1]),
      .u_o    (row_u[k+1]),
      .v_o    (row_v[k+1]),
      .cnt_o  (row_cnt[k+1])
    );
  end

  assign tail_ctrl = row_ctrl[NB];
  assign tail_cnt  = row_cnt[NB];

  // Unfold the octant step into a full-turn step, then wrap modulo 128.
  // A zero vector counts no boundary and lands on step 0.
  always_comb begin
    oct_step = 8'(tail_cnt);
    quad_step = tail_ctrl.swapped ? (vdq_pkg::STEP_QUARTER - oct_step) : oct_step;
    unique case ({tail_ctrl.x_neg, tail_ctrl.y_neg})
      2'b00:   dir_full = quad_step;
      2'b10:   dir_full = vdq_pkg::STEP_HALF - quad_step;
      2'b11:   dir_full = vdq_pkg::STEP_HALF + quad_step;
      default: dir_full = vdq_pkg::STEP_FULL - quad_step;
    endcase
    dir_new = dir_full[vdq_pkg::DIR_W-1:0];
  end

  // Route the word leaving the row into the output register, or park it in
  // the skid register while the output holds
  always_comb begin
    out_valid_d  = out_valid_q;
    out_dir_d    = out_dir_q;
    skid_valid_d = skid_valid_q;
    skid_dir_d   = skid_dir_q;
    if (adv) begin
      if (tail_ctrl.valid) begin
        if (!out_valid_q || take) begin
          out_valid_d = 1'b1;
          out_dir_d   = dir_new;
        end else begin
          skid_valid_d = 1'b1;
          skid_dir_d   = dir_new;
        end
      end else if (take) begin
        out_valid_d = 1'b0;
      end
    end else if (take) begin
      out_valid_d  = 1'b1;
      out_dir_d    = skid_dir_q;
      skid_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_dir_q  <= out_dir_d;
    skid_dir_q <= skid_dir_d;
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.direction = out_dir_q;

endmodule

// ----- tb/sv/tb_vector_direction_quantizer.sv -----
module tb_vector_direction_quantizer;
  import vdq_pkg::*;

  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int C_MIN = -(1 <<< (CW - 1));
  localparam int C_MAX = (1 <<< (CW - 1)) - 1;

  // Random part of the stimulus and the run limits
  localparam int RAND_WORDS  = 1250;
  localparam int HOLDOFF_LEN = 400;
  localparam int TAIL_CYCLES = 60;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_REPORTS = 50;
  localparam int TAYLOR_N    = 24;

  // pi and 1.0 with 100 fraction bits, for the boundary tables
  localparam logic [127:0] PI_Q100  = 128'h3243F6A8885A308D313198A2E0;
  localparam logic [127:0] ONE_Q100 = 128'd1 << 100;
  localparam real          PI_R     = 3.14159265358979;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_HALF,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_e;

  // One input word, plus a flag that makes the sender wait for an empty pipe first
  typedef struct packed {
    logic signed [CW-1:0] fx;
    logic signed [CW-1:0] fy;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic                 drain_first;
  } coord_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  vdq_in_if #(.COORD_WIDTH(CW)) item_if ();
  vdq_out_if                    result_if ();

  vector_direction_quantizer #(
    .COORD_WIDTH(CW)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Words waiting to be sent, and headings waiting to come out
  coord_word_t          coord_queue[$];
  logic [DIR_W-1:0]     heading_queue[$];

  // sin and cos of the octant boundaries (2j+1)*pi/128, 100 fraction bits
  logic [127:0] bound_sin_q[NUM_BOUNDS];
  logic [127:0] bound_cos_q[NUM_BOUNDS];

  int   words_in;
  int   words_out;
  int   mismatch_count;
  int   quiet_cycles;
  logic drain_next;

  // (a*b) >> 100, kept to 128 bits
  function automatic logic [127:0] q100_mul(input logic [127:0] a, input logic [127:0] b);
    logic [255:0] prod;
    prod = 256'(a) * 256'(b);
    return prod[227:100];
  endfunction

  // Build the boundary tables from Taylor series; far more precision than the
  // tightest integer vector of this width needs.
  initial begin : trig_tables
    logic [127:0] x;
    logic [127:0] x2;
    logic [127:0] st;
    logic [127:0] ct;
    logic [127:0] ss;
    logic [127:0] cs;
    for (int j = 0; j < NUM_BOUNDS; j++) begin
      x  = (PI_Q100 * 128'(2 * j + 1)) >> 7;
      x2 = q100_mul(x, x);
      st = x;
      ss = x;
      ct = ONE_Q100;
      cs = ONE_Q100;
      for (int k = 1; k <= TAYLOR_N; k++) begin
        st = q100_mul(st, x2) / 128'(2 * k * (2 * k + 1));
        ct = q100_mul(ct, x2) / 128'((2 * k - 1) * 2 * k);
        if (k % 2 == 1) begin
          ss = ss - st;
          cs = cs - ct;
        end else begin
          ss = ss + st;
          cs = cs + ct;
        end
      end
      bound_sin_q[j] = ss;
      bound_cos_q[j] = cs;
    end
  end

  // Heading of (front - back) in 1/128 turn, nearest step, modulo 128.
  // Fold into the first octant, count the boundaries below the angle by an
  // exact cross-product test, then unfold by symmetry.
  function automatic logic [DIR_W-1:0] heading_step(
    input logic signed [CW-1:0] fx,
    input logic signed [CW-1:0] fy,
    input logic signed [CW-1:0] bx,
    input logic signed [CW-1:0] by
  );
    logic signed [CW+1:0] dx;
    logic signed [CW+1:0] dy;
    logic [CW:0]          ax;
    logic [CW:0]          ay;
    logic [CW:0]          u;
    logic [CW:0]          v;
    logic                 swapped;
    logic                 dx_neg;
    logic                 dy_neg;
    logic [7:0]           s;
    logic [7:0]           q;
    logic [7:0]           d;
    dx      = fx - bx;
    dy      = fy - by;
    dx_neg  = dx[CW+1];
    dy_neg  = dy[CW+1];
    ax      = (CW+1)'(dx_neg ? -dx : dx);
    ay      = (CW+1)'(dy_neg ? -dy : dy);
    swapped = ay > ax;
    u       = swapped ? ay : ax;
    v       = swapped ? ax : ay;
    s       = 8'd0;
    for (int j = 0; j < NUM_BOUNDS; j++) begin
      if (128'(v) * bound_cos_q[j] > 128'(u) * bound_sin_q[j]) s = s + 8'd1;
    end
    q = swapped ? STEP_QUARTER - s : s;
    if (!dx_neg && !dy_neg) begin
      d = q;
    end else if (dx_neg && !dy_neg) begin
      d = STEP_HALF - q;
    end else if (dx_neg) begin
      d = STEP_HALF + q;
    end else begin
      d = STEP_FULL - q;
    end
    return d[DIR_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    if (mismatch_count < MAX_REPORTS)
      $display("mismatch: %s, expected %0d, got %0d", what, want_v, got_v);
    mismatch_count++;
  endtask

  // Append one word; take the drain flag if one is pending
  task automatic queue_coords(input int fx, input int fy, input int bx, input int by);
    coord_word_t w;
    w.fx          = CW'(fx);
    w.fy          = CW'(fy);
    w.bx          = CW'(bx);
    w.by          = CW'(by);
    w.drain_first = drain_next;
    drain_next    = 1'b0;
    coord_queue.push_back(w);
  endtask

  // Pick a back point so that back + d stays in the coordinate range
  function automatic int place_back(input int d);
    int lo;
    int hi;
    lo = (d < 0) ? C_MIN - d : C_MIN;
    hi = (d > 0) ? C_MAX - d : C_MAX;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic queue_vector(input int dx, input int dy);
    int bx;
    int by;
    bx = place_back(dx);
    by = place_back(dy);
    queue_coords(bx + dx, by + dy, bx, by);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(7))
      0:       return C_MIN;
      1:       return C_MIN + 1;
      2:       return -2;
      3:       return -1;
      4:       return 0;
      5:       return 1;
      6:       return C_MAX - 1;
      default: return C_MAX;
    endcase
  endfunction

  // Sender: bursts of random length, random gaps between them. Hold a word
  // until it is taken; before a drain-flagged word, wait for an empty pipe.
  int burst_left;
  int gap_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        heading_queue.push_back(heading_step(item_if.front_x, item_if.front_y,
                                             item_if.back_x, item_if.back_y));
        coord_queue.delete(0);
        words_in <= words_in + 1;
      end
      if (!item_if.valid || item_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_if.valid <= 1'b0;
        end else if (coord_queue.size() != 0 &&
                     (!coord_queue[0].drain_first ||
                      (!item_if.valid && words_in == words_out))) begin
          item_if.valid   <= 1'b1;
          item_if.front_x <= coord_queue[0].fx;
          item_if.front_y <= coord_queue[0].fy;
          item_if.back_x  <= coord_queue[0].bx;
          item_if.back_y  <= coord_queue[0].by;
          burst_left--;
          if (burst_left <= 0) begin
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(9) == 0) ? int'($urandom_range(300, 100))
                                                  : int'($urandom_range(40, 1));
            if ($urandom_range(3) == 0)
              gap_left = 0;
            else if ($urandom_range(9) == 0)
              gap_left = int'($urandom_range(40, 10));
            else
              gap_left = int'($urandom_range(6, 1));
          end
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each heading with the oldest expectation, then pick the
  // next ready from the current stall pattern. Two long hold-offs fill the pipe
  // and push back on the sender.
  rx_mode_e         rx_mode;
  int               mode_left;
  int               holdoff_left;
  logic [DIR_W-1:0] want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      rx_mode      = RX_ALWAYS;
      mode_left    = 100;
      holdoff_left = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (heading_queue.size() == 0) begin
          report_mismatch("direction word with nothing expected", -1,
                          int'(result_if.direction));
        end else begin
          want = heading_queue.pop_front();
          if (result_if.direction !== want)
            report_mismatch("direction", int'(want), int'(result_if.direction));
        end
        words_out <= words_out + 1;
        if (words_out == 200 || words_out == 700) holdoff_left = HOLDOFF_LEN;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(3));
        mode_left = int'($urandom_range(256, 64));
      end else begin
        mode_left--;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        result_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: result_if.ready <= 1'b1;
          RX_HALF:   result_if.ready <= 1'($urandom_range(1));
          RX_SPARSE: result_if.ready <= ($urandom_range(3) == 0);
          default:   result_if.ready <= ($urandom_range(3) != 0);
        endcase
      end
    end
  end

  // Count cycles in which neither side moves a word
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int  pick;
    int  k;
    int  dx;
    int  dy;
    int  mag;
    real ang;
    real rad;

    // Drive every input to a known value before the first edge
    rst_ni            = 1'b0;
    item_if.valid     = 1'b0;
    item_if.front_x   = '0;
    item_if.front_y   = '0;
    item_if.back_x    = '0;
    item_if.back_y    = '0;
    result_if.ready   = 1'b0;
    words_in          = 0;
    words_out         = 0;
    mismatch_count    = 0;
    quiet_cycles      = 0;
    drain_next        = 1'b0;

    // Directed: zero vectors, full-range differences, axes, diagonals,
    // the wrap below +x, swapped octants and a vector close to a quarter step
    queue_coords(0, 0, 0, 0);
    queue_coords(C_MAX, C_MAX, C_MAX, C_MAX);
    queue_coords(C_MIN, C_MIN, C_MIN, C_MIN);
    queue_coords(C_MAX, 0, C_MIN, 0);
    queue_coords(C_MIN, 0, C_MAX, 0);
    queue_coords(0, C_MAX, 0, C_MIN);
    queue_coords(0, C_MIN, 0, C_MAX);
    queue_coords(C_MAX, C_MAX, C_MIN, C_MIN);
    queue_coords(C_MIN, C_MAX, C_MAX, C_MIN);
    queue_coords(C_MIN, C_MIN, C_MAX, C_MAX);
    queue_coords(C_MAX, C_MIN, C_MIN, C_MAX);
    queue_coords(1, 0, 0, 0);
    queue_coords(0, 1, 0, 0);
    queue_coords(-1, 0, 0, 0);
    queue_coords(0, -1, 0, 0);
    queue_coords(C_MAX, -1, C_MIN, 0);
    queue_coords(1000, -30, 0, 0);
    queue_coords(-1000, -30, 0, 0);
    queue_coords(3, 7, 0, 0);
    queue_coords(-7, 3, 0, 0);
    queue_coords(7, -3, 0, 0);
    queue_coords(C_MIN, C_MAX, C_MIN, C_MIN);
    queue_coords(C_MAX, C_MIN, C_MAX, C_MAX);
    queue_coords(20000, 491, -20000, 0);

    // Random: raw fields, short vectors, vectors next to a half step,
    // axes and diagonals, and fields at their extremes
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == 400 || i == 900) drain_next = 1'b1;
      pick = int'($urandom_range(99));
      if (pick < 30) begin
        queue_coords(int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()));
      end else if (pick < 55) begin
        queue_vector(int'($urandom_range(80)) - 40, int'($urandom_range(80)) - 40);
      end else if (pick < 80) begin
        k   = int'($urandom_range(127));
        rad = real'($urandom_range(60000, 8));
        ang = (real'(k) + 0.5) * PI_R / 64.0;
        dx  = $rtoi(rad * $cos(ang)) + int'($urandom_range(2)) - 1;
        dy  = $rtoi(rad * $sin(ang)) + int'($urandom_range(2)) - 1;
        queue_vector(dx, dy);
      end else if (pick < 90) begin
        mag = int'($urandom_range(65535));
        queue_vector((int'($urandom_range(2)) - 1) * mag, (int'($urandom_range(2)) - 1) * mag);
      end else begin
        queue_coords(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every word to go in and every heading to come out
    while (coord_queue.size() != 0 || item_if.valid || heading_queue.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && heading_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
